FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, sampled on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MFB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// shared types, constants and helpers of the mono frame buffer
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int ROWS         = 64;
  localparam int ROW_BYTES    = 40;
  localparam int PIX_PER_BYTE = 6;
  localparam int COLS         = ROW_BYTES * PIX_PER_BYTE;
  localparam int DEPTH        = ROWS * ROW_BYTES;
  localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W        = $clog2(ROW_BYTES + 1);
  // x + width + step stays below 512
  localparam int COORD_W      = 9;
  localparam int DIV6_MUL     = 171;
  localparam int DIV6_SHIFT   = 10;

  typedef enum logic [2:0] {
    REQ_HLINE   = 3'd0,
    REQ_VLINE   = 3'd1,
    REQ_RECT    = 3'd2,
    REQ_CLEAR   = 3'd3,
    REQ_REFRESH = 3'd4
  } req_e;

  localparam logic LCD_SET_ADDR   = 1'b0;
  localparam logic LCD_WRITE_DATA = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] start_x;
    logic [5:0] start_y;
    logic [7:0] span_width;
    logic [7:0] span_height;
    logic [5:0] refresh_row;
  } in_item_t;

  typedef struct packed {
    logic        lcd_command;
    logic [15:0] lcd_value;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic cap_req;
    logic sweep_step;
    logic sweep_shown;
    logic seg_load;
    logic seg_next;
    logic pix_step;
    logic pix_rd;
    logic pix_wr;
    logic cnt_clr;
    logic cmp_rd;
    logic emit_rd;
    logic ld_start;
    logic ld_row;
    logic ld_byte;
    logic ld_last;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic seg_last;
    logic pix_cnt_zero;
    logic pix_in_range;
    logic cmp_last;
    logic bytes_done;
    logic differ;
    logic row_zero;
    logic row_ok;
    logic out_free;
  } dp_status_t;

  // floor(val / 6) by reciprocal multiply, exact for val below 512
  function automatic logic [COORD_W-1:0] div6(input logic [COORD_W-1:0] val);
    logic [COORD_W+DIV6_SHIFT-1:0] prod;
    prod = (COORD_W+DIV6_SHIFT)'(val) * (COORD_W+DIV6_SHIFT)'(DIV6_MUL);
    return prod[COORD_W+DIV6_SHIFT-1:DIV6_SHIFT];
  endfunction

endpackage

FILE: hdl/mfb_ctrl.sv
// ----------------------------------------------------------------------------
// mfb_ctrl
// sequencer for drawing, clearing and row refresh
// ----------------------------------------------------------------------------
module mfb_ctrl import mfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] req_type,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_SWEEP_ALL   = 10'b0000000001,
    S_SWEEP_DRAWN = 10'b0000000010,
    S_IDLE        = 10'b0000000100,
    S_SEG         = 10'b0000001000,
    S_PIX         = 10'b0000010000,
    S_WR          = 10'b0000100000,
    S_CMP         = 10'b0001000000,
    S_CMP_END     = 10'b0010000000,
    S_ROW_ADDR    = 10'b0100000000,
    S_BYTE        = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP_ALL;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_SWEEP_ALL: begin
        cmd.sweep_step  = 1'b1;
        cmd.sweep_shown = 1'b1;
        if (status.sweep_last) state_next = S_IDLE;
      end
      S_SWEEP_DRAWN: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_req = 1'b1;
          unique case (req_type)
            REQ_HLINE, REQ_VLINE, REQ_RECT: state_next = S_SEG;
            REQ_CLEAR:                      state_next = S_SWEEP_DRAWN;
            REQ_REFRESH: begin
              cmd.cnt_clr = 1'b1;
              state_next  = S_CMP;
            end
            default:                        state_next = S_IDLE;
          endcase
        end
      end
      S_SEG: begin
        cmd.seg_load = 1'b1;
        state_next   = S_PIX;
      end
      S_PIX: begin
        if (status.pix_cnt_zero) begin
          if (status.seg_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.seg_next = 1'b1;
            state_next   = S_SEG;
          end
        end else begin
          cmd.pix_step = 1'b1;
          if (status.pix_in_range) begin
            cmd.pix_rd = 1'b1;
            state_next = S_WR;
          end
        end
      end
      S_WR: begin
        cmd.pix_wr = 1'b1;
        state_next = S_PIX;
      end
      S_CMP: begin
        if (!status.row_ok) begin
          state_next = S_IDLE;
        end else begin
          cmd.cmp_rd = 1'b1;
          if (status.cmp_last) state_next = S_CMP_END;
        end
      end
      S_CMP_END: begin
        cmd.cnt_clr = 1'b1;
        if (status.row_zero) begin
          if (status.out_free) begin
            cmd.ld_start = 1'b1;
            cmd.ld_last  = !status.differ;
            state_next   = status.differ ? S_ROW_ADDR : S_IDLE;
          end
        end else begin
          state_next = status.differ ? S_ROW_ADDR : S_IDLE;
        end
      end
      S_ROW_ADDR: begin
        if (status.out_free) begin
          cmd.ld_row  = 1'b1;
          cmd.emit_rd = 1'b1;
          state_next  = S_BYTE;
        end
      end
      S_BYTE: begin
        if (status.out_free) begin
          cmd.ld_byte = 1'b1;
          cmd.ld_last = status.bytes_done;
          if (status.bytes_done) begin
            state_next = S_IDLE;
          end else begin
            cmd.emit_rd = 1'b1;
          end
        end
      end
      default: state_next = S_SWEEP_ALL;
    endcase
  end

endmodule

FILE: hdl/mfb_datapath.sv
// ----------------------------------------------------------------------------
// mfb_datapath
// frame memories, shape walker, row compare and result register
// ----------------------------------------------------------------------------
module mfb_datapath import mfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic [15:0]        start_addr;
  logic [7:0]         base_x;
  logic [5:0]         base_y;
  logic [7:0]         span_w;
  logic [7:0]         span_h;
  logic [1:0]         seg;
  logic [1:0]         seg_end;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [7:0]         pix_cnt;
  logic               horiz;
  logic [ADDR_W-1:0]  pix_waddr;
  logic [5:0]         pix_mask;
  logic [ADDR_W-1:0]  row_base;
  logic               row_zero;
  logic               row_ok;
  logic [CNT_W-1:0]   byte_cnt;
  logic               cmp_wr;
  logic [ADDR_W-1:0]  cmp_addr;
  logic               row_diff;
  logic [ADDR_W-1:0]  sweep_addr;

  logic [5:0] drawn_mem [DEPTH];
  logic [5:0] shown_mem [DEPTH];
  logic [5:0] drawn_q;
  logic [5:0] shown_q;

  logic [COORD_W-1:0] seg_x;
  logic [COORD_W-1:0] seg_y;
  logic [7:0]         seg_len;
  logic               seg_horiz;
  logic [COORD_W-1:0] pix_q;
  logic [COORD_W-1:0] pix_rem_w;
  logic [ADDR_W-1:0]  pix_addr;
  logic [5:0]         pix_bit;
  logic [ADDR_W-1:0]  row_addr;
  logic               drawn_re;
  logic [ADDR_W-1:0]  drawn_raddr;
  logic               drawn_we;
  logic [ADDR_W-1:0]  drawn_waddr;
  logic [5:0]         drawn_wdata;
  logic               shown_we;
  logic [ADDR_W-1:0]  shown_waddr;
  logic [5:0]         shown_wdata;
  logic               shown_re;

  // segment table: top, left, bottom, right edge
  always_comb begin
    case (seg)
      2'd0: begin
        seg_x = COORD_W'(base_x);  seg_y = COORD_W'(base_y);
        seg_len = span_w;          seg_horiz = 1'b1;
      end
      2'd1: begin
        seg_x = COORD_W'(base_x);  seg_y = COORD_W'(base_y);
        seg_len = span_h;          seg_horiz = 1'b0;
      end
      2'd2: begin
        seg_x = COORD_W'(base_x);
        seg_y = COORD_W'(base_y) + COORD_W'(span_h);
        seg_len = span_w;          seg_horiz = 1'b1;
      end
      default: begin
        seg_x = COORD_W'(base_x) + COORD_W'(span_w);
        seg_y = COORD_W'(base_y);
        seg_len = span_h;          seg_horiz = 1'b0;
      end
    endcase
  end

  // pixel to word address and bit, leftmost column at bit 5
  always_comb begin
    pix_q     = div6(cur_x);
    pix_rem_w = cur_x - COORD_W'(pix_q * COORD_W'(PIX_PER_BYTE));
    pix_addr  = ADDR_W'(cur_y) * ADDR_W'(ROW_BYTES) + ADDR_W'(pix_q);
    pix_bit   = 6'b100000 >> pix_rem_w[2:0];
  end

  assign row_addr = row_base + ADDR_W'(byte_cnt);

  always_comb begin
    drawn_re    = cmd.pix_rd | cmd.cmp_rd;
    drawn_raddr = cmd.pix_rd ? pix_addr : row_addr;
    shown_re    = cmd.cmp_rd | cmd.emit_rd;

    drawn_we    = 1'b0;
    drawn_waddr = pix_waddr;
    drawn_wdata = drawn_q | pix_mask;
    if (cmd.sweep_step) begin
      drawn_we    = 1'b1;
      drawn_waddr = sweep_addr;
      drawn_wdata = '0;
    end else if (cmp_wr) begin
      drawn_we    = 1'b1;
      drawn_waddr = cmp_addr;
      drawn_wdata = '0;
    end else if (cmd.pix_wr) begin
      drawn_we    = 1'b1;
    end

    shown_we    = 1'b0;
    shown_waddr = cmp_addr;
    shown_wdata = drawn_q;
    if (cmd.sweep_step && cmd.sweep_shown) begin
      shown_we    = 1'b1;
      shown_waddr = sweep_addr;
      shown_wdata = '0;
    end else if (cmp_wr) begin
      shown_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drawn_we) drawn_mem[drawn_waddr] <= drawn_wdata;
    if (drawn_re) drawn_q <= drawn_mem[drawn_raddr];
  end

  always_ff @(posedge clk) begin
    if (shown_we) shown_mem[shown_waddr] <= shown_wdata;
    if (shown_re) shown_q <= shown_mem[row_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= '0;
      sweep_addr <= '0;
      byte_cnt   <= '0;
      cmp_wr     <= 1'b0;
      row_diff   <= 1'b0;
      seg        <= '0;
      seg_end    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) start_addr <= cfg_wr_data;

      if (cmd.sweep_step) begin
        sweep_addr <= status.sweep_last ? '0 : sweep_addr + ADDR_W'(1);
      end

      if (cmd.cnt_clr) begin
        byte_cnt <= '0;
      end else if (cmd.cmp_rd || cmd.emit_rd) begin
        byte_cnt <= byte_cnt + CNT_W'(1);
      end

      cmp_wr <= cmd.cmp_rd;

      if (cmd.cap_req) begin
        row_diff <= 1'b0;
      end else if (cmp_wr && (drawn_q != shown_q)) begin
        row_diff <= 1'b1;
      end

      if (cmd.cap_req) begin
        seg     <= (in_data.req_type == REQ_VLINE) ? 2'd1 : 2'd0;
        seg_end <= (in_data.req_type == REQ_RECT)  ? 2'd3 :
                   (in_data.req_type == REQ_VLINE) ? 2'd1 : 2'd0;
      end else if (cmd.seg_next) begin
        seg <= seg + 2'd1;
      end

      if (cmd.ld_start || cmd.ld_row || cmd.ld_byte) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      base_x   <= in_data.start_x;
      base_y   <= in_data.start_y;
      span_w   <= in_data.span_width;
      span_h   <= in_data.span_height;
      row_base <= ADDR_W'(32'(in_data.refresh_row) * ROW_BYTES);
      row_zero <= (in_data.refresh_row == '0);
      row_ok   <= (32'(in_data.refresh_row) < ROWS);
    end

    if (cmd.seg_load) begin
      cur_x   <= seg_x;
      cur_y   <= seg_y;
      pix_cnt <= seg_len;
      horiz   <= seg_horiz;
    end else if (cmd.pix_step) begin
      pix_cnt <= pix_cnt - 8'd1;
      if (horiz) begin
        cur_x <= cur_x + COORD_W'(1);
      end else begin
        cur_y <= cur_y + COORD_W'(1);
      end
    end

    if (cmd.pix_rd) begin
      pix_waddr <= pix_addr;
      pix_mask  <= pix_bit;
    end

    if (cmd.cmp_rd) cmp_addr <= row_addr;

    if (cmd.ld_start) begin
      out_data.lcd_command <= LCD_SET_ADDR;
      out_data.lcd_value   <= start_addr;
      out_data.last_of_run <= cmd.ld_last;
    end else if (cmd.ld_row) begin
      out_data.lcd_command <= LCD_SET_ADDR;
      out_data.lcd_value   <= start_addr + 16'(row_base);
      out_data.last_of_run <= 1'b0;
    end else if (cmd.ld_byte) begin
      out_data.lcd_command <= LCD_WRITE_DATA;
      out_data.lcd_value   <= 16'(shown_q);
      out_data.last_of_run <= cmd.ld_last;
    end
  end

  always_comb begin
    status.sweep_last   = (sweep_addr == ADDR_W'(DEPTH - 1));
    status.seg_last     = (seg == seg_end);
    status.pix_cnt_zero = (pix_cnt == '0);
    status.pix_in_range = (cur_x < COORD_W'(COLS)) && (cur_y < COORD_W'(ROWS));
    status.cmp_last     = (byte_cnt == CNT_W'(ROW_BYTES - 1));
    status.bytes_done   = (byte_cnt == CNT_W'(ROW_BYTES));
    status.differ       = row_diff | (cmp_wr & (drawn_q != shown_q));
    status.row_zero     = row_zero;
    status.row_ok       = row_ok;
    status.out_free     = !out_valid | out_ready;
  end

endmodule

FILE: hdl/mono_framebuffer_draw_and_row_refresh_unit.sv
// drawing: a line or edge is walked segment by segment; a drawn pixel is read and
//   written back, a clipped pixel skipped; clear zeroes the whole drawn frame
// refresh: a compare pass over the ROW_BYTES words of the row, then one result
//   per cycle while the sink is ready (up to 42 results)
// reset: synchronous; a clearing pass over ROWS*ROW_BYTES words (2560) zeroes both
//   frames, input ready stays low until it ends, config writes are taken meanwhile
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_and_row_refresh_unit
// monochrome frame store with line/rectangle drawing and row-wise display refresh
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_and_row_refresh_unit import mfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // display access channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // graphic start address register
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // command and status bundles between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: owns request handshake, walks segments, pixels and row bytes
  mfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (in_data.req_type),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: drawn and shown frame memories, pixel read-modify-write,
  // row compare with copy and clear, and the output register that lets
  // a finished result wait while the next request is taken
  mfb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

FILE: hdl/mfb_checker.sv
// ----------------------------------------------------------------------------
// mfb_checker
// port-level checks of the frame buffer, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfb_checker import mfb_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result holds
  `MFB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // drawing, clear and unused requests never start a result
  `MFB_ASSERT_NEXT(a_draw_silent, in_valid && in_ready && (in_data.req_type != REQ_REFRESH), !$rose(out_valid), "result after non-refresh request")

  // data bytes carry only six pixels
  `MFB_ASSERT_IMPL(a_byte_width, out_valid && (out_data.lcd_command == LCD_WRITE_DATA), out_data.lcd_value[15:6] == '0, "data byte wider than six pixels")

  // refresh keeps the request side busy right after it is taken
  `MFB_ASSERT_NEXT(a_refresh_busy, in_valid && in_ready && (in_data.req_type == REQ_REFRESH), !in_ready, "ready right after refresh request")

endmodule

bind mono_framebuffer_draw_and_row_refresh_unit mfb_checker u_mfb_checker (.*);

FILE: tb/tb_mono_framebuffer_draw_and_row_refresh_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_draw_and_row_refresh_unit
// self-checking bench: drives drawing, clear and row refresh requests with
// random idling on both channels, tracks both frames in its own copy and
// compares every display access in order against the predicted stream
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_draw_and_row_refresh_unit;
  import mfb_pkg::*;

  // request codes the block ignores
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
  // longest silent work: clear frame or a full-size rectangle
  localparam int SETTLE_CYCLES = 3000;
  localparam int PRINT_LIMIT   = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  mono_framebuffer_draw_and_row_refresh_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // frame copies and start address as the block should hold them
  bit [5:0]    drawn_px [ROWS][ROW_BYTES];
  bit [5:0]    shown_px [ROWS][ROW_BYTES];
  logic [15:0] graphic_base = '0;

  in_item_t    pending_requests[$];
  out_item_t   lcd_accesses_due[$];
  out_item_t   due_access;

  int error_count  = 0;
  int access_count = 0;
  int in_gap       = 0;
  int out_gap      = 0;
  bit in_idle_en   = 1'b0;
  bit out_idle_en  = 1'b0;
  int focus_row    = 0;

  task automatic report_error(string msg);
    if (error_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void set_pixel(int x, int y);
    if (y < ROWS && x < COLS)
      drawn_px[y][x / PIX_PER_BYTE][PIX_PER_BYTE - 1 - x % PIX_PER_BYTE] = 1'b1;
  endfunction

  function automatic void draw_hrun(int x, int y, int len);
    for (int i = 0; i < len; i++) set_pixel(x + i, y);
  endfunction

  function automatic void draw_vrun(int x, int y, int len);
    for (int i = 0; i < len; i++) set_pixel(x, y + i);
  endfunction

  // updates the frames for one request and queues the display accesses it causes
  function automatic void apply_request(in_item_t r);
    out_item_t burst[$];
    int        row;
    bit        differ;
    int        x;
    int        y;
    int        w;
    int        h;
    x = r.start_x;
    y = r.start_y;
    w = r.span_width;
    h = r.span_height;
    row = r.refresh_row;
    case (r.req_type)
      REQ_HLINE: draw_hrun(x, y, w);
      REQ_VLINE: draw_vrun(x, y, h);
      REQ_RECT: begin
        // right edge stops one short of the bottom edge, corner stays clear
        draw_hrun(x, y, w);
        draw_vrun(x, y, h);
        draw_hrun(x, y + h, w);
        draw_vrun(x + w, y, h);
      end
      REQ_CLEAR: begin
        foreach (drawn_px[i, j]) drawn_px[i][j] = '0;
      end
      REQ_REFRESH: begin
        if (row == 0) burst.push_back('{LCD_SET_ADDR, graphic_base, 1'b0});
        if (row < ROWS) begin
          differ = 1'b0;
          for (int b = 0; b < ROW_BYTES; b++)
            if (drawn_px[row][b] != shown_px[row][b]) differ = 1'b1;
          if (differ) begin
            burst.push_back('{LCD_SET_ADDR, 16'(graphic_base + ROW_BYTES * row), 1'b0});
            for (int b = 0; b < ROW_BYTES; b++)
              burst.push_back('{LCD_WRITE_DATA, {10'b0, drawn_px[row][b]}, 1'b0});
          end
          for (int b = 0; b < ROW_BYTES; b++) begin
            shown_px[row][b] = drawn_px[row][b];
            drawn_px[row][b] = '0;
          end
        end
      end
      default: ;
    endcase
    if (burst.size() > 0) begin
      burst[burst.size() - 1].last_of_run = 1'b1;
      foreach (burst[i]) lcd_accesses_due.push_back(burst[i]);
    end
  endfunction

  function automatic in_item_t make_req(logic [2:0] kind, int x, int y, int w, int h,
                                        int row);
    in_item_t r;
    r.req_type    = kind;
    r.start_x     = 8'(x);
    r.start_y     = 6'(y);
    r.span_width  = 8'(w);
    r.span_height = 8'(h);
    r.refresh_row = 6'(row);
    return r;
  endfunction

  // mostly short spans, now and then up to the full field
  function automatic logic [7:0] pick_span();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 24));
  endfunction

  // draws aimed at rows that are refreshed soon after, plus clears and noise
  task automatic fill_random(int count);
    in_item_t r;
    int       pick;
    repeat (count) begin
      r.start_x     = 8'($urandom);
      r.start_y     = 6'($urandom);
      r.span_width  = pick_span();
      r.span_height = pick_span();
      r.refresh_row = 6'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        r.req_type = REQ_HLINE;
        focus_row = r.start_y;
      end else if (pick < 40) begin
        r.req_type = REQ_VLINE;
        focus_row = 6'(r.start_y + $urandom_range(0, r.span_height));
      end else if (pick < 55) begin
        r.req_type = REQ_RECT;
        focus_row = ($urandom_range(0, 1) == 0) ? int'(r.start_y)
                                                : int'(6'(r.start_y + r.span_height));
      end else if (pick < 58) begin
        r.req_type = REQ_CLEAR;
      end else if (pick < 61) begin
        r.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
      end else begin
        r.req_type = REQ_REFRESH;
        if ($urandom_range(0, 7) == 0) r.refresh_row = '0;
        else if ($urandom_range(0, 1) == 0) r.refresh_row = 6'(focus_row);
      end
      pending_requests.push_back(r);
    end
  endtask

  // all requests taken, every access seen, then room for silent drawing work
  task automatic settle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || lcd_accesses_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_base(logic [15:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    graphic_base = value;
    @(negedge clk);
  endtask

  // request side: holds each request until taken, random gaps between requests
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_request(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_data  <= pending_requests.pop_front();
          in_valid <= 1'b1;
          if (in_idle_en && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // display side: checks each access against the oldest one due, random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (lcd_accesses_due.size() == 0) begin
          report_error($sformatf("access %0d not expected: cmd %0d value %h last %0d",
                                 access_count, out_data.lcd_command, out_data.lcd_value,
                                 out_data.last_of_run));
        end else begin
          due_access = lcd_accesses_due.pop_front();
          if (out_data.lcd_command !== due_access.lcd_command)
            report_error($sformatf("access %0d lcd_command %0d, want %0d", access_count,
                                   out_data.lcd_command, due_access.lcd_command));
          if (out_data.lcd_value !== due_access.lcd_value)
            report_error($sformatf("access %0d lcd_value %h, want %h", access_count,
                                   out_data.lcd_value, due_access.lcd_value));
          if (out_data.last_of_run !== due_access.last_of_run)
            report_error($sformatf("access %0d last_of_run %0d, want %0d", access_count,
                                   out_data.last_of_run, due_access.last_of_run));
        end
        access_count++;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_idle_en && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 7);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;

    // directed part, start address still at its reset value
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 0));     // clean row 0
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 37));    // clean row
    pending_requests.push_back(make_req(REQ_HLINE, 0, 0, 240, 0, 0));     // full row
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 0));     // back to blank
    pending_requests.push_back(make_req(REQ_HLINE, 235, 63, 255, 0, 0));  // clipped right
    pending_requests.push_back(make_req(REQ_VLINE, 239, 60, 0, 255, 0));  // clipped below
    pending_requests.push_back(make_req(REQ_VLINE, 255, 0, 0, 10, 0));    // fully outside
    pending_requests.push_back(make_req(REQ_HLINE, 100, 20, 0, 7, 0));    // zero span
    pending_requests.push_back(make_req(REQ_VLINE, 100, 20, 7, 0, 0));    // zero span
    pending_requests.push_back(make_req(REQ_RECT, 10, 10, 20, 5, 0));
    pending_requests.push_back(make_req(REQ_RECT, 230, 58, 255, 255, 0));
    pending_requests.push_back(make_req(REQ_RECT, 50, 30, 0, 0, 0));      // empty outline
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 10));
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 15));    // missing corner
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 63));
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 60));
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 58));
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 20));    // nothing drawn
    pending_requests.push_back(make_req(REQ_HLINE, 7, 3, 50, 0, 0));
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 3));
    pending_requests.push_back(make_req(REQ_HLINE, 7, 3, 50, 0, 0));
    pending_requests.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(REQ_REFRESH, 0, 0, 0, 0, 3));     // shown line wiped
    pending_requests.push_back(make_req(REQ_SPARE_LAST, 255, 63, 255, 255, 63));
    pending_requests.push_back(make_req(REQ_SPARE_FIRST, 255, 63, 255, 255, 0));
    settle();

    // top of the address space, row addresses wrap
    write_base(16'hFFFF);
    fill_random(120);
    settle();

    write_base(16'($urandom));
    fill_random(115);
    settle();

    // last part runs without idling on either side
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    write_base(16'hF6A0);
    fill_random(110);
    settle();

    if (error_count == 0) begin
      $display("mono_framebuffer_draw_and_row_refresh_unit verification clean");
    end else begin
      $display("mono_framebuffer_draw_and_row_refresh_unit verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("mono_framebuffer_draw_and_row_refresh_unit verification failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/mfb_pkg.sv
hdl/mfb_ctrl.sv
hdl/mfb_datapath.sv
hdl/mono_framebuffer_draw_and_row_refresh_unit.sv
hdl/mfb_checker.sv
tb/tb_mono_framebuffer_draw_and_row_refresh_unit.sv
